// ----- sv/cdsi_pkg.sv -----
// Shared types and codes for the depth-sorted render list.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cdsi_pkg;

  localparam int LIST_DEPTH_DEF = 64;

  localparam int TAG_W    = 10;
  localparam int DEPTH_W  = 16;
  localparam int POS_W    = 16;
  localparam int EXT_W    = 15;
  localparam int HALF_W   = 15;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 7;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CULLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

  localparam logic REG_HALF_W = 1'b0;
  localparam logic REG_HALF_H = 1'b1;

  localparam logic [HALF_W-1:0] HALF_W_RESET = 15'd1920;
  localparam logic [HALF_W-1:0] HALF_H_RESET = 15'd1280;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic signed [DEPTH_W-1:0] depth;
  } cdsi_entry_t;

  // Broadcast from the list controller to every cell of the chain.
  typedef struct packed {
    logic        insert_en;
    logic        rotate_en;
    cdsi_entry_t new_entry;
  } cdsi_ctl_t;

endpackage

`default_nettype wire

// ----- sv/cull_depth_sorted_insert.sv -----
// Top level of the depth-sorted render list with rectangle culling.
// Depends on cdsi_pkg, cdsi_cull and cdsi_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one command per transfer:
//   clear, cull-and-insert, or read out. Command code 3 is taken and
//   ignored. Results leave on out_valid/out_ready through one output
//   register; last marks the final result of each command.
//   Clear and insert complete in the cycle of the transfer; their single
//   result is valid on the next cycle. An insert compares its depth in
//   every cell of the chain at once and shifts the tail by one cell.
//   A read of N entries gives N results, one per cycle while out_ready
//   holds, taken from the head cell while the chain rotates by one; after
//   N steps the list is back in place. The first entry passes through the
//   state register and then the output register. in_ready is low during
//   a readout, so no other command is taken until the read has ended.
//   When the receiver stalls, the output register holds and the block
//   stops: no new transfer is taken and a readout pauses.
//   Reset empties the list (counts to zero), loads the default screen
//   half sizes and drops any pending result. Cell contents are kept.
//   Configuration writes take effect at the clock edge of cfg_we.
`default_nettype none

module cull_depth_sorted_insert #(
  parameter int LIST_DEPTH = cdsi_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [cdsi_pkg::HALF_W-1:0]          cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           command,
  input  wire logic signed [cdsi_pkg::POS_W-1:0]    pos_x,
  input  wire logic signed [cdsi_pkg::POS_W-1:0]    pos_y,
  input  wire logic signed [cdsi_pkg::DEPTH_W-1:0]  depth,
  input  wire logic [cdsi_pkg::EXT_W-1:0]           extent_w,
  input  wire logic [cdsi_pkg::EXT_W-1:0]           extent_h,
  input  wire logic                                 in_top,
  input  wire logic [cdsi_pkg::TAG_W-1:0]           tag,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [cdsi_pkg::STATUS_W-1:0]             status,
  output logic [cdsi_pkg::TAG_W-1:0]                out_tag,
  output logic signed [cdsi_pkg::DEPTH_W-1:0]       out_depth,
  output logic                                      out_top,
  output logic [cdsi_pkg::TOTAL_W-1:0]              top_total,
  output logic                                      last
);
  import cdsi_pkg::*;

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  lower_count, top_count, lower_count_next, top_count_next;
  logic [CNT_W-1:0]  total, lo, hi, total_m1;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next, tail_idx;
  logic [HALF_W-1:0] half_w, half_h;

  logic              accept, room, culled, full, insert_ok, rd_last, cmd_result;
  cdsi_ctl_t         ctl;
  cdsi_entry_t       cell_q [LIST_DEPTH];
  logic              cell_ins [LIST_DEPTH];

  cdsi_cull u_cull (
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .extent_w (extent_w),
    .extent_h (extent_h),
    .half_w   (half_w),
    .half_h   (half_h),
    .culled   (culled)
  );

  always_comb begin
    total     = lower_count + top_count;
    total_m1  = total - 1'b1;
    tail_idx  = total_m1[IDX_W-1:0];
    full      = (total == CNT_W'(LIST_DEPTH));
    lo        = in_top ? lower_count : '0;
    hi        = in_top ? total : lower_count;
    room      = !out_valid || out_ready;
    in_ready  = !rst && (state == S_IDLE) && room;
    accept    = in_valid && in_ready;
    insert_ok = accept && (command == CMD_INSERT) && !culled && !full;
    rd_last   = (rd_idx == tail_idx);
    // A read of a nonempty list reports through the readout steps instead.
    cmd_result = accept && ((command inside {CMD_CLEAR, CMD_INSERT}) ||
                            (command == CMD_READ && total == '0));

    ctl.insert_en     = insert_ok;
    ctl.rotate_en     = (state == S_READ) && room;
    ctl.new_entry.tag   = tag;
    ctl.new_entry.depth = depth;
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    cdsi_entry_t prev_e, next_e;
    logic        ins_p;
    if (i == 0) begin : g_head
      assign prev_e = ctl.new_entry;
      assign ins_p  = 1'b0;
    end else begin : g_body
      assign prev_e = cell_q[i-1];
      assign ins_p  = cell_ins[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_end
      assign next_e = cell_q[0];
    end else begin : g_mid
      assign next_e = cell_q[i+1];
    end

    cdsi_cell #(
      .LIST_DEPTH (LIST_DEPTH),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .lo         (lo),
      .hi         (hi),
      .tail_idx   (tail_idx),
      .ins_prev   (ins_p),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .head_entry (cell_q[0]),
      .entry      (cell_q[i]),
      .ins        (cell_ins[i])
    );
  end

  always_comb begin
    state_next       = state;
    rd_idx_next      = rd_idx;
    lower_count_next = lower_count;
    top_count_next   = top_count;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_CLEAR) begin
            lower_count_next = '0;
            top_count_next   = '0;
          end else if (insert_ok) begin
            if (in_top) begin
              top_count_next = top_count + 1'b1;
            end else begin
              lower_count_next = lower_count + 1'b1;
            end
          end else if (command == CMD_READ && total != '0) begin
            state_next  = S_READ;
            rd_idx_next = '0;
          end
        end
      end
      S_READ: begin
        if (room) begin
          rd_idx_next = rd_idx + 1'b1;
          if (rd_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lower_count <= '0;
      top_count   <= '0;
      rd_idx      <= '0;
      half_w      <= HALF_W_RESET;
      half_h      <= HALF_H_RESET;
    end else begin
      state       <= state_next;
      lower_count <= lower_count_next;
      top_count   <= top_count_next;
      rd_idx      <= rd_idx_next;
      if (cfg_we) begin
        if (cfg_index == REG_HALF_W) begin
          half_w <= cfg_data;
        end else begin
          half_h <= cfg_data;
        end
      end
    end
  end

  // Output register: a result from a command transfer or one readout step.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_result || ctl.rotate_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rotate_en) begin
      status    <= ST_ENTRY;
      out_tag   <= cell_q[0].tag;
      out_depth <= cell_q[0].depth;
      out_top   <= (CNT_W'(rd_idx) >= lower_count);
      top_total <= TOTAL_W'(top_count);
      last      <= rd_last;
    end else if (cmd_result) begin
      out_tag   <= '0;
      out_depth <= '0;
      out_top   <= 1'b0;
      top_total <= TOTAL_W'(top_count_next);
      last      <= 1'b1;
      case (command)
        CMD_CLEAR:  status <= ST_OK;
        CMD_INSERT: status <= culled ? ST_CULLED : (full ? ST_FULL : ST_OK);
        CMD_READ:   status <= ST_EMPTY;
        default:    status <= ST_OK;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/cdsi_cull.sv -----
// Screen-rectangle cull test on doubled coordinates.
// Depends on cdsi_pkg for field widths.
`default_nettype none

module cdsi_cull (
  input  wire logic signed [cdsi_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [cdsi_pkg::POS_W-1:0] pos_y,
  input  wire logic [cdsi_pkg::EXT_W-1:0]        extent_w,
  input  wire logic [cdsi_pkg::EXT_W-1:0]        extent_h,
  input  wire logic [cdsi_pkg::HALF_W-1:0]       half_w,
  input  wire logic [cdsi_pkg::HALF_W-1:0]       half_h,
  output logic                                   culled
);
  import cdsi_pkg::*;

  // 18 bits hold every doubled position plus or minus an extent exactly.
  logic signed [17:0] x2, y2, w18, h18, bx, by;
  logic signed [17:0] x_lo, x_hi, y_lo, y_hi;

  always_comb begin
    x2   = {pos_x[POS_W-1], pos_x, 1'b0};
    y2   = {pos_y[POS_W-1], pos_y, 1'b0};
    w18  = {3'b000, extent_w};
    h18  = {3'b000, extent_h};
    bx   = {2'b00, half_w, 1'b0};
    by   = {2'b00, half_h, 1'b0};
    x_lo = x2 - w18;
    x_hi = x2 + w18;
    y_lo = y2 - h18;
    y_hi = y2 + h18;
    culled = (x_lo > bx) || (x_hi < -bx) || (y_lo > by) || (y_hi < -by);
  end

endmodule

`default_nettype wire

// ----- sv/cdsi_cell.sv -----
// One cell of the sorted list chain: holds a single entry.
// On insert it keeps, takes the new entry or takes its left neighbor;
// on readout it rotates toward the head. Depends on cdsi_pkg.
`default_nettype none

module cdsi_cell #(
  parameter int LIST_DEPTH = cdsi_pkg::LIST_DEPTH_DEF,
  parameter int INDEX      = 0,
  localparam int IDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire cdsi_pkg::cdsi_ctl_t   ctl,
  input  wire logic [CNT_W-1:0]      lo,
  input  wire logic [CNT_W-1:0]      hi,
  input  wire logic [IDX_W-1:0]      tail_idx,
  input  wire logic                  ins_prev,
  input  wire cdsi_pkg::cdsi_entry_t prev_entry,
  input  wire cdsi_pkg::cdsi_entry_t next_entry,
  input  wire cdsi_pkg::cdsi_entry_t head_entry,
  output cdsi_pkg::cdsi_entry_t      entry,
  output logic                       ins
);
  import cdsi_pkg::*;

  logic is_tail;

  // The insert flag is false before the insert point and true from it on,
  // so the first cell that raises it takes the new entry.
  always_comb begin
    ins = (CNT_W'(INDEX) >= hi) ||
          ((CNT_W'(INDEX) >= lo) && (entry.depth > ctl.new_entry.depth));
    is_tail = (IDX_W'(INDEX) == tail_idx);
  end

  always_ff @(posedge clk) begin
    if (ctl.insert_en) begin
      if (ins_prev) begin
        entry <= prev_entry;
      end else if (ins) begin
        entry <= ctl.new_entry;
      end
    end else if (ctl.rotate_en) begin
      entry <= is_tail ? head_entry : next_entry;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cdsi_checker.sv -----
// Port-level checks for the depth-sorted render list, bound to the top.
// Depends on cdsi_pkg for status and command codes.
`default_nettype none

module cdsi_port_checker #(
  parameter int LIST_DEPTH = cdsi_pkg::LIST_DEPTH_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic [1:0]                          command,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [cdsi_pkg::STATUS_W-1:0]       status,
  input wire logic [cdsi_pkg::TAG_W-1:0]          out_tag,
  input wire logic signed [cdsi_pkg::DEPTH_W-1:0] out_depth,
  input wire logic [cdsi_pkg::TOTAL_W-1:0]        top_total,
  input wire logic                                last
);
  import cdsi_pkg::*;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_tag) &&
      $stable(out_depth) && $stable(last))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Only readout entries can be followed by more results of the same command.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ENTRY |-> last)
    else $error("single-result status without last");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> top_total <= TOTAL_W'(LIST_DEPTH))
    else $error("top partition count exceeds list depth");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_CLEAR |=>
      out_valid && status == ST_OK && top_total == '0 && last)
    else $error("clear did not report an empty list");

endmodule

bind cull_depth_sorted_insert cdsi_port_checker #(.LIST_DEPTH(LIST_DEPTH)) u_cdsi_checker (.*);

`default_nettype wire

// ----- tb/sv/cdsi_checker.sv -----
// Scoreboard for the depth-sorted render list: watches config writes and both channels,
// keeps its own copy of the list and compares every result transfer. Depends on cdsi_pkg.
`timescale 1ns / 1ps

module cdsi_checker #(
  parameter int LIST_DEPTH = cdsi_pkg::LIST_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [cdsi_pkg::HALF_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [1:0]                            command,
  input  logic signed [cdsi_pkg::POS_W-1:0]     pos_x,
  input  logic signed [cdsi_pkg::POS_W-1:0]     pos_y,
  input  logic signed [cdsi_pkg::DEPTH_W-1:0]   depth,
  input  logic [cdsi_pkg::EXT_W-1:0]            extent_w,
  input  logic [cdsi_pkg::EXT_W-1:0]            extent_h,
  input  logic                                  in_top,
  input  logic [cdsi_pkg::TAG_W-1:0]            tag,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [cdsi_pkg::STATUS_W-1:0]         status,
  input  logic [cdsi_pkg::TAG_W-1:0]            out_tag,
  input  logic signed [cdsi_pkg::DEPTH_W-1:0]   out_depth,
  input  logic                                  out_top,
  input  logic [cdsi_pkg::TOTAL_W-1:0]          top_total,
  input  logic                                  last,
  output int                                    mismatch_count,
  output int                                    results_outstanding,
  output int                                    results_checked
);
  import cdsi_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]       st;
    logic [TAG_W-1:0]          tg;
    logic signed [DEPTH_W-1:0] dp;
    logic                      tp;
    logic [TOTAL_W-1:0]        tops;
    logic                      lst;
  } list_result_t;

  cdsi_entry_t         slots [LIST_DEPTH];
  int                  lower_n;
  int                  top_n;
  logic [HALF_W-1:0]   half_w_q;
  logic [HALF_W-1:0]   half_h_q;
  list_result_t        results_due [$];

  initial begin
    mismatch_count = 0;
    results_checked = 0;
    results_outstanding = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // The bounds are compared on doubled values so odd extents need no rounding.
  function automatic bit off_screen(input logic signed [POS_W-1:0] px,
                                    input logic signed [POS_W-1:0] py,
                                    input logic [EXT_W-1:0] w,
                                    input logic [EXT_W-1:0] h);
    longint bx, by, x2, y2;
    bx = 2 * longint'(half_w_q);
    by = 2 * longint'(half_h_q);
    x2 = 2 * longint'(px);
    y2 = 2 * longint'(py);
    return (x2 - longint'(w) > bx) || (x2 + longint'(w) < -bx) ||
           (y2 - longint'(h) > by) || (y2 + longint'(h) < -by);
  endfunction

  task automatic push_result(input logic [STATUS_W-1:0] st, input logic [TAG_W-1:0] tg,
                             input logic signed [DEPTH_W-1:0] dp, input logic tp,
                             input logic lst);
    list_result_t r;
    r.st = st;
    r.tg = tg;
    r.dp = dp;
    r.tp = tp;
    r.tops = TOTAL_W'(top_n);
    r.lst = lst;
    results_due.push_back(r);
  endtask

  task automatic step_render_list(input logic [1:0] cmd,
                                  input logic signed [POS_W-1:0] px,
                                  input logic signed [POS_W-1:0] py,
                                  input logic signed [DEPTH_W-1:0] d,
                                  input logic [EXT_W-1:0] w,
                                  input logic [EXT_W-1:0] h,
                                  input logic top_sel,
                                  input logic [TAG_W-1:0] tg);
    int total, lo, hi, pos, i;
    total = lower_n + top_n;
    case (cmd)
      CMD_CLEAR: begin
        lower_n = 0;
        top_n = 0;
        push_result(ST_OK, '0, '0, 1'b0, 1'b1);
      end
      CMD_INSERT: begin
        if (off_screen(px, py, w, h)) begin
          push_result(ST_CULLED, '0, '0, 1'b0, 1'b1);
        end else if (total >= LIST_DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b0, 1'b1);
        end else begin
          lo = top_sel ? lower_n : 0;
          hi = top_sel ? total : lower_n;
          pos = lo;
          // Equal depths go behind the ones already held, which keeps the order stable.
          while (pos < hi && $signed(slots[pos].depth) <= d) pos++;
          for (i = total; i > pos; i--) slots[i] = slots[i-1];
          slots[pos].tag = tg;
          slots[pos].depth = d;
          if (top_sel) top_n++;
          else lower_n++;
          push_result(ST_OK, '0, '0, 1'b0, 1'b1);
        end
      end
      CMD_READ: begin
        if (total == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b0, 1'b1);
        end else begin
          for (i = 0; i < total; i++)
            push_result(ST_ENTRY, slots[i].tag, slots[i].depth, i >= lower_n,
                        i == total - 1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      lower_n = 0;
      top_n = 0;
      half_w_q = HALF_W_RESET;
      half_h_q = HALF_H_RESET;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HALF_W) half_w_q = cfg_data;
        else half_h_q = cfg_data;
      end
      // Results from earlier commands are older than anything taken at this edge.
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result transfer with nothing expected, status", status, -1);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (out_tag !== want.tg) report_mismatch("out_tag", out_tag, want.tg);
          if (out_depth !== want.dp) report_mismatch("out_depth", out_depth, want.dp);
          if (out_top !== want.tp) report_mismatch("out_top", out_top, want.tp);
          if (top_total !== want.tops) report_mismatch("top_total", top_total, want.tops);
          if (last !== want.lst) report_mismatch("last", last, want.lst);
        end
      end
      if (in_valid && in_ready)
        step_render_list(command, pos_x, pos_y, depth, extent_w, extent_h, in_top, tag);
    end
    results_outstanding <= results_due.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the render list testbench: clock, reset, stimulus, config phases and verdict.
// Depends on cdsi_pkg, cdsi_checker and the cull_depth_sorted_insert block.
`timescale 1ns / 1ps

module testbench;
  import cdsi_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TIMEOUT_NS  = 20_000_000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = REG_HALF_W;
  logic [HALF_W-1:0]         cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                command = CMD_CLEAR;
  logic signed [POS_W-1:0]   pos_x = '0;
  logic signed [POS_W-1:0]   pos_y = '0;
  logic signed [DEPTH_W-1:0] depth = '0;
  logic [EXT_W-1:0]          extent_w = '0;
  logic [EXT_W-1:0]          extent_h = '0;
  logic                      in_top = 1'b0;
  logic [TAG_W-1:0]          tag = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [TAG_W-1:0]          out_tag;
  logic signed [DEPTH_W-1:0] out_depth;
  logic                      out_top;
  logic [TOTAL_W-1:0]        top_total;
  logic                      last;

  int mismatch_total;
  int results_outstanding;
  int results_seen;

  // quiet and hold_long are shared between the stimulus and the result-side process.
  bit quiet = 1'b0;
  bit hold_long = 1'b0;
  logic [HALF_W-1:0] cur_hw = HALF_W_RESET;
  logic [HALF_W-1:0] cur_hh = HALF_H_RESET;
  int n_insert = 0, n_read = 0, n_clear = 0, n_unused = 0, n_settings = 0;

  cull_depth_sorted_insert i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .pos_x(pos_x), .pos_y(pos_y), .depth(depth),
    .extent_w(extent_w), .extent_h(extent_h), .in_top(in_top), .tag(tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_tag(out_tag), .out_depth(out_depth), .out_top(out_top),
    .top_total(top_total), .last(last)
  );

  cdsi_checker i_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .pos_x(pos_x), .pos_y(pos_y), .depth(depth),
    .extent_w(extent_w), .extent_h(extent_h), .in_top(in_top), .tag(tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_tag(out_tag), .out_depth(out_depth), .out_top(out_top),
    .top_total(top_total), .last(last),
    .mismatch_count(mismatch_total),
    .results_outstanding(results_outstanding),
    .results_checked(results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding", results_outstanding);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Called at a clock edge; returns at the edge where the transfer happened.
  task automatic offer(input logic [1:0] cmd, input int px, input int py, input int d,
                       input int w, input int h, input int tp, input int tg);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    pos_x    <= px[POS_W-1:0];
    pos_y    <= py[POS_W-1:0];
    depth    <= d[DEPTH_W-1:0];
    extent_w <= w[EXT_W-1:0];
    extent_h <= h[EXT_W-1:0];
    in_top   <= tp[0];
    tag      <= tg[TAG_W-1:0];
    do @(posedge clk); while (in_ready !== 1'b1);
    case (cmd)
      CMD_INSERT: n_insert++;
      CMD_READ:   n_read++;
      CMD_CLEAR:  n_clear++;
      default:    n_unused++;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    // An ignored command leaves no result behind, so an empty result queue does not show that it was taken.
    repeat (4) @(posedge clk);
  endtask

  task automatic set_screen(input logic [HALF_W-1:0] hw, input logic [HALF_W-1:0] hh);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_W;
    cfg_data  <= hw;
    @(posedge clk);
    cfg_index <= REG_HALF_H;
    cfg_data  <= hh;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_hw = hw;
    cur_hh = hh;
    n_settings++;
  endtask

  // Mostly items that land on screen for the current bounds; noise items are uniform.
  task automatic offer_random_insert(input bit noise);
    int w, h, lx, ly, px, py, d;
    w = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32767)) :
                                      int'($urandom_range(0, 600));
    h = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32767)) :
                                      int'($urandom_range(0, 600));
    if (noise) begin
      px = int'($urandom_range(0, 65535)) - 32768;
      py = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      lx = (2 * int'(cur_hw) + w) / 2;
      ly = (2 * int'(cur_hh) + h) / 2;
      if (lx > 32767) lx = 32767;
      if (ly > 32767) ly = 32767;
      px = int'($urandom_range(0, 2 * lx)) - lx;
      py = int'($urandom_range(0, 2 * ly)) - ly;
      if ($urandom_range(0, 9) == 0 && lx < 32767) px = lx + 1;
      if ($urandom_range(0, 9) == 0 && ly < 32767) py = ly + 1;
    end
    d = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 6)) - 3 :
                                      int'($urandom_range(0, 65535)) - 32768;
    offer(CMD_INSERT, px, py, d, w, h, $urandom_range(0, 1), $urandom_range(0, 1023));
  endtask

  task automatic run_random(input int count);
    int n, r;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r >= 93) begin
        offer(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
      end else begin
        if (r < 66) offer_random_insert(1'b0);
        else if (r < 74) offer_random_insert(1'b1);
        else if (r < 87)
          offer(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
        else
          offer(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
        n++;
      end
    end
  endtask

  initial begin
    int i, ph, waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset bounds: 1920 by 1280 half sizes.
    offer(CMD_READ,   0, 0, 0, 0, 0, 0, 0);
    offer(CMD_INSERT, 0, 0, 0, 0, 0, 0, 1);
    offer(CMD_INSERT, 0, 0, -32768, 32767, 32767, 0, 1023);
    offer(CMD_INSERT, 0, 0, 32767, 0, 0, 0, 0);
    offer(CMD_INSERT, 0, 0, 0, 0, 0, 0, 2);
    offer(CMD_INSERT, 0, 0, 5, 0, 0, 1, 3);
    offer(CMD_INSERT, 0, 0, -32768, 0, 0, 1, 4);
    offer(CMD_INSERT, 0, 0, 32767, 0, 0, 1, 5);
    offer(CMD_INSERT, 0, 0, 5, 0, 0, 1, 6);
    // Exactly on the bounds is visible; one step further out is culled.
    offer(CMD_INSERT, 1920, 0, 1, 0, 0, 0, 7);
    offer(CMD_INSERT, 1921, 0, 1, 1, 0, 0, 9);
    offer(CMD_INSERT, -1920, 1280, 1, 0, 0, 1, 8);
    offer(CMD_INSERT, -1921, 0, 1, 1, 0, 1, 10);
    offer(CMD_INSERT, 0, 1281, 1, 0, 1, 0, 11);
    offer(CMD_INSERT, 0, -1281, 1, 0, 1, 0, 12);
    offer(CMD_INSERT, 32767, -32768, 1, 0, 0, 0, 13);
    offer(CMD_INSERT, -32768, 32767, 1, 32767, 32767, 1, 14);
    offer(CMD_UNUSED, 32767, 32767, 32767, 32767, 32767, 1, 1023);
    offer(CMD_READ,   0, 0, 0, 0, 0, 0, 0);
    offer(CMD_CLEAR,  0, 0, 0, 0, 0, 0, 0);
    offer(CMD_READ,   0, 0, 0, 0, 0, 0, 0);

    wait_drained();
    set_screen('0, '0);
    offer(CMD_INSERT, 0, 0, 0, 0, 0, 0, 15);
    offer(CMD_INSERT, 1, 0, 0, 1, 0, 1, 16);
    offer(CMD_READ,   0, 0, 0, 0, 0, 0, 0);

    wait_drained();
    set_screen('1, '1);
    offer(CMD_INSERT, 32767, 32767, 0, 0, 0, 1, 17);
    offer(CMD_INSERT, -32768, 0, 0, 0, 0, 0, 18);
    offer(CMD_READ,   0, 0, 0, 0, 0, 0, 0);
    offer(CMD_CLEAR,  0, 0, 0, 0, 0, 0, 0);

    for (ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: set_screen(HALF_W_RESET, HALF_H_RESET);
        1: set_screen('0, '1);
        2: set_screen('1, '0);
        3: set_screen($urandom_range(0, 4000), $urandom_range(0, 4000));
        default: set_screen($urandom_range(0, 32767), $urandom_range(0, 32767));
      endcase
      run_random(45);
    end

    // Fill the list while results are held off, so the input stalls behind them.
    wait_drained();
    set_screen(HALF_W_RESET, HALF_H_RESET);
    offer(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    hold_long = 1'b1;
    for (i = 0; i < LIST_DEPTH_DEF; i++)
      offer(CMD_INSERT, 0, 0, int'($urandom_range(0, 65535)) - 32768, 0, 0,
            $urandom_range(0, 1), i);
    offer(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
    // A culled item is reported as culled even when the list is full.
    offer(CMD_INSERT, 32767, 0, 0, 0, 0, 0, 100);
    offer(CMD_INSERT, 0, 0, 0, 0, 0, 1, 101);
    offer(CMD_INSERT, 0, 0, 0, 0, 0, 0, 102);
    wait_drained();
    offer(CMD_READ, 0, 0, 0, 0, 0, 0, 0);

    quiet = 1'b1;
    offer(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    run_random(30);
    offer(CMD_READ, 0, 0, 0, 0, 0, 0, 0);

    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (results_outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d inserts, %0d reads, %0d clears and %0d ignored commands",
             n_insert, n_read, n_clear, n_unused);
    $display("over %0d screen settings; %0d results checked, %0d still outstanding.",
             n_settings, results_seen, results_outstanding);
    if (mismatch_total == 0 && results_outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
